FILE: src/sm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared types and constants for the front end, word queue and round core.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam logic [31:0] IV0 = 32'h7380166f;
    localparam logic [31:0] IV1 = 32'h4914b2b9;
    localparam logic [31:0] IV2 = 32'h172442d7;
    localparam logic [31:0] IV3 = 32'hda8a0600;
    localparam logic [31:0] IV4 = 32'ha96f30bc;
    localparam logic [31:0] IV5 = 32'h163138aa;
    localparam logic [31:0] IV6 = 32'he38dee4d;
    localparam logic [31:0] IV7 = 32'hb0fb0e4e;
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_MARK = 32'h80000000;
    localparam logic [3:0]  LEN_POS  = 4'd14;

    // One word pushed into the block buffer, with a flag marking the final
    // word of a message (digest is emitted after that block is compressed).
    typedef struct packed {
        logic [31:0] data;
        logic        fin;
    } qword_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

FILE: src/sm3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message words and for digests.
// ----------------------------------------------------------------------------
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_hi;
    logic [63:0] digest_mid_hi;
    logic [63:0] digest_mid_lo;
    logic [63:0] digest_lo;
    modport source (output valid, digest_hi, digest_mid_hi, digest_mid_lo, digest_lo,
                    input ready);
    modport sink   (input valid, digest_hi, digest_mid_hi, digest_mid_lo, digest_lo,
                    output ready);
endinterface

FILE: src/sm3_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3 hash with padding and a 256-bit digest output.
// ----------------------------------------------------------------------------
// Usage: message bytes enter on in_ch as big-endian 32-bit words, first byte
// in bits 31:24. byte_count gives the valid bytes from the top and counts only
// on the word marked last; other words always count as four bytes.
// The front end tracks the bit length and appends the 0x80 marker, zero fill
// and the 64-bit length; words pass through a four-entry queue to the round
// core, which loads 16 words (one per cycle while the queue holds words) and
// then runs 64 rounds at one per cycle. After the last word the front end
// pushes padding at one word per cycle while the queue has room; one or two
// final blocks are then compressed and the digest appears on out_ch. One
// digest is held in an output register; if the receiver stalls the core
// waits before writing the next one, and the queue then back-pressures in_ch.
// Reset restores the initial value, clears the counters and drops any partial
// message.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
    input  logic       clk,
    input  logic       rst_n,
    sm3_in_if.sink     in_ch,
    sm3_out_if.source  out_ch
);
    import sm3_pkg::*;

    qword_t f_data, c_data;
    logic   f_valid, f_ready, c_valid, c_ready;

    sm3_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_data  (f_data),
        .q_valid (f_valid),
        .q_ready (f_ready)
    );

    sm3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_data),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (c_data),
        .rd_valid (c_valid),
        .rd_ready (c_ready)
    );

    sm3_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (c_data),
        .q_valid (c_valid),
        .q_ready (c_ready),
        .out_ch  (out_ch)
    );

endmodule

FILE: src/sm3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 front end
// Accepts message words, counts bits and generates the padding words.
// ----------------------------------------------------------------------------
module sm3_front (
    input  logic             clk,
    input  logic             rst_n,
    sm3_in_if.sink           in_ch,
    output sm3_pkg::qword_t  q_data,
    output logic             q_valid,
    input  logic             q_ready
);
    import sm3_pkg::*;

    typedef enum logic [1:0] {
        S_PASS,
        S_FILL,
        S_LEN_HI,
        S_LEN_LO
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] hold_reg, hold_next;    // 0x80 marker word still to push
    logic        hold_v_reg, hold_v_next;

    logic [2:0]  cnt;
    logic [31:0] keep;
    logic [63:0] len_add;
    logic        push;

    assign cnt = (!in_ch.last || in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
    assign len_add = len_reg + {58'd0, cnt, 3'b000};

    always_comb
    begin
        case (cnt)
            3'd0:    keep = 32'h00000000;
            3'd1:    keep = 32'hff000000;
            3'd2:    keep = 32'hffff0000;
            3'd3:    keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
    end

    assign in_ch.ready = (state_reg == S_PASS) && q_ready;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        hold_next   = hold_reg;
        hold_v_next = hold_v_reg;
        q_valid     = 1'b0;
        q_data      = '{data: 32'd0, fin: 1'b0};
        case (state_reg)
            S_PASS:
            begin
                q_valid = in_ch.valid;
                if (!in_ch.last || cnt == 3'd4)
                    q_data.data = in_ch.data_word;
                else
                    q_data.data = (in_ch.data_word & keep) | (PAD_MARK >> {cnt, 3'b000});
                if (in_ch.valid && q_ready)
                begin
                    len_next = len_add;
                    pos_next = pos_reg + 4'd1;
                    if (in_ch.last)
                    begin
                        hold_next   = PAD_MARK;
                        hold_v_next = (cnt == 3'd4);
                        state_next  = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                q_valid = 1'b1;
                if (hold_v_reg)
                    q_data.data = hold_reg;
                else if (pos_reg == LEN_POS)
                    q_data.data = len_reg[63:32];
                if (q_ready)
                begin
                    pos_next    = pos_reg + 4'd1;
                    hold_v_next = 1'b0;
                    if (!hold_v_reg && pos_reg == LEN_POS)
                        state_next = S_LEN_LO;
                end
            end
            S_LEN_LO:
            begin
                q_valid     = 1'b1;
                q_data.data = len_reg[31:0];
                q_data.fin  = 1'b1;
                if (q_ready)
                begin
                    pos_next   = 4'd0;
                    len_next   = 64'd0;
                    state_next = S_PASS;
                end
            end
            default:
            begin
                state_next = S_PASS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_PASS;
            pos_reg    <= 4'd0;
            len_reg    <= 64'd0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

FILE: src/sm3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 word queue
// Four-entry FIFO between the front end and the round core.
// ----------------------------------------------------------------------------
module sm3_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  sm3_pkg::qword_t  wr_data,
    input  logic             wr_valid,
    output logic             wr_ready,
    output sm3_pkg::qword_t  rd_data,
    output logic             rd_valid,
    input  logic             rd_ready
);
    import sm3_pkg::*;

    qword_t     mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

FILE: src/sm3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 round core
// Collects 16-word blocks, expands on the fly and runs 64 rounds per block.
// ----------------------------------------------------------------------------
module sm3_core (
    input  logic             clk,
    input  logic             rst_n,
    input  sm3_pkg::qword_t  q_data,
    input  logic             q_valid,
    output logic             q_ready,
    sm3_out_if.source        out_ch
);
    import sm3_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [3:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic [31:0] w_reg [16];     // sliding window of expanded words W[j..j+15]
    logic [31:0] cv_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] tr_reg;         // round constant already rotated by j
    logic        ov_reg;
    logic [63:0] d0_reg, d1_reg, d2_reg, d3_reg;

    logic [31:0] wn, a12, s1, s2, f, g, t1, t2;
    logic        low;
    logic        emit;

    assign low = ~rnd_reg[5] & ~rnd_reg[4];
    assign wn  = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
               ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
    assign a12 = rotl(v_reg[0], 5'd12);
    assign s1  = rotl(a12 + v_reg[4] + tr_reg, 5'd7);
    assign s2  = s1 ^ a12;
    assign f   = low ? (v_reg[0] ^ v_reg[1] ^ v_reg[2])
                     : ((v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]));
    assign g   = low ? (v_reg[4] ^ v_reg[5] ^ v_reg[6])
                     : ((v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]));
    assign t1  = f + v_reg[3] + s2 + (w_reg[0] ^ w_reg[4]);
    assign t2  = g + v_reg[7] + s1 + w_reg[0];

    assign emit = (state_reg == S_DONE) && (!ov_reg || out_ch.ready);

    assign q_ready = (state_reg == S_LOAD);
    assign out_ch.valid         = ov_reg;
    assign out_ch.digest_hi     = d0_reg;
    assign out_ch.digest_mid_hi = d1_reg;
    assign out_ch.digest_mid_lo = d2_reg;
    assign out_ch.digest_lo     = d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pos_reg   <= 4'd0;
            rnd_reg   <= 6'd0;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            cv_reg    <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
        end
        else
        begin
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        pos_reg <= pos_reg + 4'd1;
                        if (pos_reg == 4'd15)
                        begin
                            fin_reg   <= q_data.fin;
                            rnd_reg   <= 6'd0;
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        // Fold in the working state as it stands after the last round.
                        cv_reg[0] <= cv_reg[0] ^ t1;
                        cv_reg[1] <= cv_reg[1] ^ v_reg[0];
                        cv_reg[2] <= cv_reg[2] ^ rotl(v_reg[1], 5'd9);
                        cv_reg[3] <= cv_reg[3] ^ v_reg[2];
                        cv_reg[4] <= cv_reg[4] ^ perm0(t2);
                        cv_reg[5] <= cv_reg[5] ^ v_reg[4];
                        cv_reg[6] <= cv_reg[6] ^ rotl(v_reg[5], 5'd19);
                        cv_reg[7] <= cv_reg[7] ^ v_reg[6];
                        state_reg <= fin_reg ? S_DONE : S_LOAD;
                    end
                end
                S_DONE:
                begin
                    // Wait until any earlier digest has been taken.
                    if (emit)
                    begin
                        cv_reg    <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && q_valid)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= q_data.data;
            if (pos_reg == 4'd15)
            begin
                v_reg  <= cv_reg;
                tr_reg <= T_LOW;
            end
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wn;
            tr_reg    <= (rnd_reg == 6'd15) ? rotl(T_HIGH, 5'd16) : rotl(tr_reg, 5'd1);
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= rotl(v_reg[1], 5'd9);
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1;
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= rotl(v_reg[5], 5'd19);
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= perm0(t2);
        end
        if (emit)
        begin
            d0_reg <= {cv_reg[0], cv_reg[1]};
            d1_reg <= {cv_reg[2], cv_reg[3]};
            d2_reg <= {cv_reg[4], cv_reg[5]};
            d3_reg <= {cv_reg[6], cv_reg[7]};
        end
    end

endmodule

FILE: tb/sm3_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 testbench interface note
// The channel interfaces come from the RTL source; this file only holds the
// shared bundle types used by the testbench to queue message words and digests.
// ----------------------------------------------------------------------------
package sm3_tb_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } msg_word_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mid_hi;
        logic [63:0] mid_lo;
        logic [63:0] lo;
    } digest_t;

endpackage

FILE: tb/tb_sm3_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams directed and random messages into the engine with random gaps and
// stalls, predicts every digest with an independent SM3 model and compares
// each digest field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine;
    import sm3_pkg::*;
    import sm3_tb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 400;

    logic clk;
    logic rst_n;

    sm3_in_if  in_ch ();
    sm3_out_if out_ch ();

    sm3_hash_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state
    logic [31:0] hash_state [8];
    logic [31:0] blk_words [16];
    logic [3:0]  blk_pos;
    logic [63:0] msg_bits;

    msg_word_t pending_words [$];
    digest_t   expected_digests [$];

    int  error_count;
    int  digests_seen;
    int  words_sent;
    int  messages_done;
    longint cycle_count;
    bit  stim_done;
    bit  hold_sink;
    bit  sender_pause;
    int  sink_hold_cycles;
    int  src_gap;
    int  sink_gap;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        int k;
        k = n % 32;
        if (k == 0)
            return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] p0f(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] p1f(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    task automatic reset_hash_state();
        hash_state[0] = IV0; hash_state[1] = IV1;
        hash_state[2] = IV2; hash_state[3] = IV3;
        hash_state[4] = IV4; hash_state[5] = IV5;
        hash_state[6] = IV6; hash_state[7] = IV7;
        blk_pos  = '0;
        msg_bits = '0;
    endtask

    task automatic compress_blk();
        logic [31:0] w [68];
        logic [31:0] v [8];
        logic [31:0] tj, a12, s1, s2, ff, gg, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = blk_words[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
        for (int j = 0; j < 8; j++)
            v[j] = hash_state[j];
        for (int j = 0; j < 64; j++)
        begin
            tj  = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol(v[0], 12);
            s1  = rol(a12 + v[4] + rol(tj, j), 7);
            s2  = s1 ^ a12;
            if (j < 16)
            begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end
            else
            begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            t1 = ff + v[3] + s2 + (w[j] ^ w[j+4]);
            t2 = gg + v[7] + s1 + w[j];
            v[3] = v[2];
            v[2] = rol(v[1], 9);
            v[1] = v[0];
            v[0] = t1;
            v[7] = v[6];
            v[6] = rol(v[5], 19);
            v[5] = v[4];
            v[4] = p0f(t2);
        end
        for (int j = 0; j < 8; j++)
            hash_state[j] ^= v[j];
    endtask

    task automatic append_blk_word(input logic [31:0] w);
        blk_words[blk_pos] = w;
        blk_pos = blk_pos + 4'd1;
        if (blk_pos == 4'd0)
            compress_blk();
    endtask

    // Work out the digest, if any, caused by one accepted word.
    task automatic predict_word(input msg_word_t item);
        int cnt;
        logic [31:0] keep;
        digest_t d;
        cnt = item.byte_count;
        if (cnt > 4 || !item.last)
            cnt = 4;
        msg_bits = msg_bits + 64'(cnt * 8);
        if (!item.last)
        begin
            append_blk_word(item.data_word);
            return;
        end
        if (cnt == 4)
        begin
            append_blk_word(item.data_word);
            append_blk_word(PAD_MARK);
        end
        else
        begin
            keep = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * cnt));
            append_blk_word((item.data_word & keep) | (PAD_MARK >> (8 * cnt)));
        end
        if (blk_pos > LEN_POS)
            while (blk_pos != 4'd0)
                append_blk_word(32'h0);
        while (blk_pos < LEN_POS)
            append_blk_word(32'h0);
        append_blk_word(msg_bits[63:32]);
        append_blk_word(msg_bits[31:0]);
        d.hi     = {hash_state[0], hash_state[1]};
        d.mid_hi = {hash_state[2], hash_state[3]};
        d.mid_lo = {hash_state[4], hash_state[5]};
        d.lo     = {hash_state[6], hash_state[7]};
        expected_digests = {expected_digests, d};
        reset_hash_state();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("MISMATCH digest %0d %s: got %016h expected %016h",
                 digests_seen, what, got, want);
    endtask

    task automatic queue_word(input logic [31:0] data, input int cnt, input bit fin);
        msg_word_t m;
        m.data_word  = data;
        m.byte_count = 3'(cnt);
        m.last       = fin;
        pending_words = {pending_words, m};
    endtask

    // A message of n full words followed by a final word with cnt bytes.
    task automatic queue_message(input int n, input int cnt);
        for (int i = 0; i < n; i++)
            queue_word($urandom, $urandom_range(0, 7), 1'b0);
        queue_word($urandom, cnt, 1'b1);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        reset_hash_state();
        for (int j = 0; j < 16; j++)
            blk_words[j] = '0;
    end

    // Driver
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data_word = '0;
        in_ch.byte_count = '0;
        in_ch.last = 1'b0;
        src_gap = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_word('{in_ch.data_word, in_ch.byte_count, in_ch.last});
                words_sent++;
                if (in_ch.last)
                    messages_done++;
                src_gap = pick_gap();
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (src_gap > 0 || sender_pause || pending_words.size() == 0)
                begin
                    if (src_gap > 0)
                        src_gap--;
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    msg_word_t m;
                    m = pending_words.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.data_word  <= m.data_word;
                    in_ch.byte_count <= m.byte_count;
                    in_ch.last       <= m.last;
                end
            end
        end
    end

    // Receiver and checker
    initial
    begin
        out_ch.ready = 1'b0;
        sink_gap = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_digests.size() == 0)
                begin
                    report_mismatch("unexpected", out_ch.digest_hi, 64'd0);
                end
                else
                begin
                    digest_t e;
                    e = expected_digests.pop_front();
                    if (out_ch.digest_hi !== e.hi)
                        report_mismatch("hi", out_ch.digest_hi, e.hi);
                    if (out_ch.digest_mid_hi !== e.mid_hi)
                        report_mismatch("mid_hi", out_ch.digest_mid_hi, e.mid_hi);
                    if (out_ch.digest_mid_lo !== e.mid_lo)
                        report_mismatch("mid_lo", out_ch.digest_mid_lo, e.mid_lo);
                    if (out_ch.digest_lo !== e.lo)
                        report_mismatch("lo", out_ch.digest_lo, e.lo);
                end
                digests_seen++;
            end
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                sink_gap = pick_gap();
            end
        end
    end

    // Long receiver hold-off, counted in its own process.
    always @(posedge clk)
    begin
        if (hold_sink)
        begin
            if (sink_hold_cycles > 0)
                sink_hold_cycles--;
            else
                hold_sink <= 1'b0;
        end
    end

    initial
    begin
        error_count = 0;
        digests_seen = 0;
        words_sent = 0;
        messages_done = 0;
        stim_done = 1'b0;
        hold_sink = 1'b0;
        sender_pause = 1'b0;
        sink_hold_cycles = 0;

        // Directed: empty message, each final byte count, the padding edge
        // where the marker lands in word 15, saturated counts and
        // partial counts on non-final words, and all-ones / all-zero data.
        queue_word(32'h0, 0, 1'b1);
        queue_word(32'h61626300, 3, 1'b1);
        queue_word(32'hffffffff, 4, 1'b1);
        queue_word(32'hffffffff, 1, 1'b1);
        queue_word(32'hffffffff, 2, 1'b1);
        queue_word(32'h00000000, 7, 1'b1);
        queue_word(32'hffffffff, 5, 1'b0);
        queue_word(32'hffffffff, 2, 1'b1);
        for (int i = 0; i < 14; i++)
            queue_word(32'h61626364, 4, 1'b0);
        queue_word(32'hffffffff, 4, 1'b1);
        wait (pending_words.size() == 0);
        wait (expected_digests.size() == 0);
        for (int i = 0; i < 13; i++)
            queue_word(32'haaaaaaaa, 1, 1'b0);
        queue_word(32'h55555555, 3, 1'b1);
        queue_word(32'h12345678, 6, 1'b1);

        // Long receiver stall while the sender keeps feeding words.
        wait (pending_words.size() == 0);
        sink_hold_cycles = 3000;
        hold_sink = 1'b1;
        for (int i = 0; i < 10; i++)
            queue_message($urandom_range(0, 20), $urandom_range(0, 4));

        // Sender pause until every digest is back.
        wait (pending_words.size() == 0);
        sender_pause = 1'b1;
        wait (expected_digests.size() == 0 && !hold_sink);
        repeat (200) @(posedge clk);
        sender_pause = 1'b0;

        // Random messages; mostly short, a few spanning several blocks.
        while (words_sent + pending_words.size() < 1400)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_message($urandom_range(16, 70), $urandom_range(0, 7));
            else
                queue_message($urandom_range(0, 18), $urandom_range(0, 7));
            wait (pending_words.size() < 8);
        end
        wait (pending_words.size() == 0 && !in_ch.valid);
        stim_done = 1'b1;
        wait (expected_digests.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d words in %0d messages, %0d digests checked.",
                 words_sent, messages_done, digests_seen);
        if (error_count == 0 && expected_digests.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sm3_hash_engine.f
src/sm3_pkg.sv
src/sm3_if.sv
src/sm3_front.sv
src/sm3_queue.sv
src/sm3_core.sv
src/sm3_hash_engine.sv
tb/sm3_tb_if.sv
tb/tb_sm3_hash_engine.sv
